/* rtl/pss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the positional sequence store
// Holds the operation and status codes, the cell command codes, the
// controller states and the fixed field widths.
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int PSS_CAPACITY = 16;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      OP_INS_FIRST = 3'd0,
      OP_INS_LAST  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FIRST = 3'd3,
      OP_DEL_LAST  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_READ_ALL  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK      = 2'd0,
      STS_INVALID = 2'd1,
      STS_EMPTY   = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   // The command that tells every cell of the row what to do.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_mode_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_READ = 1'b1
   } state_type;

endpackage : pss_pkg
`default_nettype wire

/* rtl/pss_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pss_cell: one storage cell of the sequence row
// Holds one word and picks its next value from itself, its neighbors,
// the head of the row or the incoming word, according to the row command.
// ----------------------------------------------------------------------------
module pss_cell
   import pss_pkg::*;
#(
   parameter int CAPACITY = PSS_CAPACITY,
   parameter int INDEX    = 0
) (
   input  wire logic                                 clock,
   input  wire cell_mode_type                        mode,
   input  wire logic [$clog2(CAPACITY+1)-1:0]        idx,
   input  wire logic [$clog2(CAPACITY+1)-1:0]        cnt,
   input  wire logic [VALUE_W-1:0]                   value,
   input  wire logic [VALUE_W-1:0]                   left_data,
   input  wire logic [VALUE_W-1:0]                   right_data,
   input  wire logic [VALUE_W-1:0]                   head_data,
   output logic      [VALUE_W-1:0]                   data
);

   localparam int IW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] MY_IDX  = IW'(INDEX);
   localparam logic [IW-1:0] MY_NEXT = IW'(INDEX + 1);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (mode)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_INSERT: begin
            if (MY_IDX == idx) begin
               data_in = value;
            end else if (MY_IDX > idx) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= idx) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            // The occupied part of the row turns left by one place.
            if (MY_NEXT < cnt) begin
               data_in = right_data;
            end else if (MY_NEXT == cnt) begin
               data_in = head_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule : pss_cell
`default_nettype wire

/* rtl/pss_chain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pss_chain: the row of storage cells
// Links each cell to its left and right neighbors and presents the word
// in the head cell.
// ----------------------------------------------------------------------------
module pss_chain
   import pss_pkg::*;
#(
   parameter int CAPACITY = PSS_CAPACITY
) (
   input  wire logic                                 clock,
   input  wire cell_mode_type                        mode,
   input  wire logic [$clog2(CAPACITY+1)-1:0]        idx,
   input  wire logic [$clog2(CAPACITY+1)-1:0]        cnt,
   input  wire logic [VALUE_W-1:0]                   value,
   output logic      [VALUE_W-1:0]                   head
);

   logic [VALUE_W-1:0] cell_data [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_w;
      logic [VALUE_W-1:0] right_w;

      // The end cells have no neighbor on one side. The first cell sees the incoming
      // word there, which is never selected; the last cell sees its own word there.
      if (i == 0) begin : g_first
         assign left_w = value;
      end else begin : g_inner_l
         assign left_w = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_inner_r
         assign right_w = cell_data[i+1];
      end

      pss_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .mode       (mode),
         .idx        (idx),
         .cnt        (cnt),
         .value      (value),
         .left_data  (left_w),
         .right_data (right_w),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   assign head = cell_data[0];

endmodule : pss_chain
`default_nettype wire

/* rtl/positional_sequence_store_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_sequence_store_top: ordered store of signed words by position
// Keeps up to CAPACITY words in a row of cells and inserts, deletes or
// reads them out in order on command.
// ----------------------------------------------------------------------------
//
//  Channel    Ports                                       Handshake
//  request    req_kind, req_value, req_position           start while busy low
//  response   rsp_status, rsp_count, rsp_element,         rsp_valid, one cycle
//             rsp_last
//
// Every insert or delete that is carried out shifts the row of cells by one
// place at the clock edge that accepts the transfer; a rejected request or
// the unused operation code leaves the row as it is. The response appears in
// the following cycle. On a read of all words the occupied part of the row
// rotates left once per cycle and the head cell is sent out each time, so
// after the last word the row is back in its original order. When more than
// one word is stored, busy is high from the cycle after the accepting edge
// until the cycle before the last word is on the response ports.
// Reset clears the word count and the controller; the
// cell contents are left as they are, since only occupied cells are read.
// The receiver cannot stall the response channel; every response is valid
// for exactly one cycle.
//
module positional_sequence_store_top
   import pss_pkg::*;
#(
   parameter int CAPACITY = PSS_CAPACITY
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [KIND_W-1:0]           req_kind,
   input  wire logic signed [VALUE_W-1:0]   req_value,
   input  wire logic [POS_W-1:0]            req_position,
   output logic                             rsp_valid,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic [COUNT_W-1:0]               rsp_count,
   output logic signed [VALUE_W-1:0]        rsp_element,
   output logic                             rsp_last
);

   // Width of counts, slot numbers and the read counter.
   localparam int IW = $clog2(CAPACITY + 1);
   // Width used to compare a request position against the count.
   localparam int CW = ((IW > POS_W) ? IW : POS_W) + 1;
   localparam logic [IW-1:0] FULL_COUNT = IW'(CAPACITY);

   // Controller state.
   state_type          state_ff;
   state_type          state_in;
   logic [IW-1:0]      count_ff;
   logic [IW-1:0]      count_in;
   logic [IW-1:0]      remain_ff;
   logic [IW-1:0]      remain_in;

   // Response register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;
   logic [VALUE_W-1:0] rsp_element_ff;
   logic [VALUE_W-1:0] rsp_element_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;

   // Command to the cell row.
   cell_mode_type      cell_mode;
   logic [IW-1:0]      cell_idx;
   logic [VALUE_W-1:0] head_word;

   logic               accept;
   logic [CW-1:0]      pos_ext;
   logic [CW-1:0]      cnt_ext;
   logic               ins_pos_ok;
   logic               del_pos_ok;
   logic               is_full;
   logic               is_empty;

   assign busy   = (state_ff == STATE_READ);
   assign accept = start && !busy;

   assign pos_ext    = CW'(req_position);
   assign cnt_ext    = CW'(count_ff);
   // Positions are 1-based; position zero is never valid.
   assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CW'(1));
   assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign is_full    = (count_ff == FULL_COUNT);
   assign is_empty   = (count_ff == '0);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = STS_OK;
      rsp_element_in = '0;
      rsp_last_in    = 1'b1;
      cell_mode      = CELL_HOLD;
      cell_idx       = '0;

      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (op_type'(req_kind))
                  OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                     // Fullness is checked before the position.
                     if (is_full) begin
                        rsp_status_in = STS_FULL;
                     end else if (op_type'(req_kind) == OP_INS_AT && !ins_pos_ok) begin
                        rsp_status_in = STS_INVALID;
                     end else begin
                        cell_mode = CELL_INSERT;
                        count_in  = count_ff + IW'(1);
                        if (op_type'(req_kind) == OP_INS_FIRST) begin
                           cell_idx = '0;
                        end else if (op_type'(req_kind) == OP_INS_LAST) begin
                           cell_idx = count_ff;
                        end else begin
                           cell_idx = IW'(req_position - POS_W'(1));
                        end
                     end
                  end
                  OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                     // Emptiness is checked before the position.
                     if (is_empty) begin
                        rsp_status_in = STS_EMPTY;
                     end else if (op_type'(req_kind) == OP_DEL_AT && !del_pos_ok) begin
                        rsp_status_in = STS_INVALID;
                     end else begin
                        cell_mode = CELL_DELETE;
                        count_in  = count_ff - IW'(1);
                        if (op_type'(req_kind) == OP_DEL_FIRST) begin
                           cell_idx = '0;
                        end else if (op_type'(req_kind) == OP_DEL_LAST) begin
                           cell_idx = count_ff - IW'(1);
                        end else begin
                           cell_idx = IW'(req_position - POS_W'(1));
                        end
                     end
                  end
                  OP_READ_ALL: begin
                     if (is_empty) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        // The first word goes out right away.
                        cell_mode      = CELL_ROTATE;
                        rsp_element_in = head_word;
                        remain_in      = count_ff - IW'(1);
                        rsp_last_in    = (count_ff == IW'(1));
                        if (count_ff != IW'(1)) begin
                           state_in = STATE_READ;
                        end
                     end
                  end
                  default: begin
                     // The unused operation code changes nothing.
                     rsp_status_in = STS_INVALID;
                  end
               endcase
            end
         end
         STATE_READ: begin
            rsp_valid_in   = 1'b1;
            cell_mode      = CELL_ROTATE;
            rsp_element_in = head_word;
            remain_in      = remain_ff - IW'(1);
            rsp_last_in    = (remain_ff == IW'(1));
            if (remain_ff == IW'(1)) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase

      // The count field carries the low bits of the count after the operation.
      rsp_count_in = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   pss_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock (clock),
      .mode  (cell_mode),
      .idx   (cell_idx),
      .cnt   (count_ff),
      .value (req_value),
      .head  (head_word)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

   // The stored count never goes past the capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("stored count exceeds capacity");

   // The count moves by at most one per cycle.
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + IW'(1)) ||
                        (count_ff == $past(count_ff) - IW'(1)))
      else $error("stored count changed by more than one");

   // A response that is not the last of its transfer is followed by more.
   a_read_continues : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("read stopped before its last word");

   // While reading out, a word is sent in the next cycle.
   a_read_emits : assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("read cycle without a response");

endmodule : positional_sequence_store_top
`default_nettype wire
